// File: hw/rtl/two_stacks_shared_array_macros.svh
// ----------------------------------------------------------------------------
// Two stacks shared array: assertion macros
// Concurrent check helpers clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef TWO_STACKS_SHARED_ARRAY_MACROS_SVH
`define TWO_STACKS_SHARED_ARRAY_MACROS_SVH

// Assert a property on every rising clock edge outside reset.
`define TSSA_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tssa check failed");

// Assert that a condition never holds outside reset.
`define TSSA_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tssa forbidden condition seen");

`endif

// File: hw/rtl/tssa_pkg.sv
// ----------------------------------------------------------------------------
// Two stacks shared array: package
// Word types, operation and status codes, controller states and commands.
// ----------------------------------------------------------------------------
package tssa_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    KIND_PUSH_A = 2'd0,
    KIND_PUSH_B = 2'd1,
    KIND_POP_A  = 2'd2,
    KIND_POP_B  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RESP = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [WORD_W-1:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value_out;
    logic [1:0]               status;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// File: hw/rtl/tssa_datapath.sv
// ----------------------------------------------------------------------------
// Two stacks shared array: datapath
// Holds the shared word store, both stack counts and the result register.
// ----------------------------------------------------------------------------
module tssa_datapath import tssa_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  in_word_t  in_data_i,
  output out_word_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem [DEPTH];

  logic [1:0]        kind_q;
  logic [WORD_W-1:0] value_q;
  logic [CW-1:0]     cnt_a_q, cnt_a_d;
  logic [CW-1:0]     cnt_b_q, cnt_b_d;
  logic [WORD_W-1:0] rdata_q;
  logic [1:0]        status_q, status_d;

  logic              full;
  logic              wr_en, rd_en;
  logic [CW-1:0]     addr_full;
  logic [AW-1:0]     addr;

  assign full = ({1'b0, cnt_a_q} + {1'b0, cnt_b_q}) >= (CW+1)'(DEPTH);

  always_comb begin
    cnt_a_d   = cnt_a_q;
    cnt_b_d   = cnt_b_q;
    status_d  = STAT_OK;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    addr_full = '0;
    unique case (kind_e'(kind_q))
      KIND_PUSH_A: begin
        addr_full = cnt_a_q;
        if (full) begin
          status_d = STAT_OVERFLOW;
        end else begin
          wr_en   = 1'b1;
          cnt_a_d = cnt_a_q + CW'(1);
        end
      end
      KIND_PUSH_B: begin
        addr_full = CW'(DEPTH - 1) - cnt_b_q;
        if (full) begin
          status_d = STAT_OVERFLOW;
        end else begin
          wr_en   = 1'b1;
          cnt_b_d = cnt_b_q + CW'(1);
        end
      end
      KIND_POP_A: begin
        addr_full = cnt_a_q - CW'(1);
        if (cnt_a_q == '0) begin
          status_d = STAT_UNDERFLOW;
        end else begin
          rd_en   = 1'b1;
          cnt_a_d = cnt_a_q - CW'(1);
        end
      end
      KIND_POP_B: begin
        addr_full = CW'(DEPTH) - cnt_b_q;
        if (cnt_b_q == '0) begin
          status_d = STAT_UNDERFLOW;
        end else begin
          rd_en   = 1'b1;
          cnt_b_d = cnt_b_q - CW'(1);
        end
      end
      default: status_d = STAT_OK;
    endcase
  end

  assign addr = addr_full[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
    end else if (cmd_i.exec) begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= in_data_i.kind;
      value_q <= in_data_i.value_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[addr] <= value_q;
    end
  end

  // Zero for pushes and refused pops
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rdata_q  <= rd_en ? mem[addr] : '0;
      status_q <= status_d;
    end
  end

  assign out_data_o.value_out = rdata_q;
  assign out_data_o.status    = status_q;

endmodule

// File: hw/rtl/tssa_ctrl.sv
// ----------------------------------------------------------------------------
// Two stacks shared array: controller
// Sequences accept, execute and respond for one word at a time.
// ----------------------------------------------------------------------------
module tssa_ctrl import tssa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: begin
        if (!out_stall_i) state_d = in_valid_i ? ST_EXEC : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_EXEC: in_stall_o = 1'b1;
      ST_RESP: begin
        out_valid_o = 1'b1;
        // take the next word as the result leaves
        in_stall_o  = out_stall_i;
      end
      default: in_stall_o = 1'b1;
    endcase
    cmd_o.load = in_valid_i && !in_stall_o;
    cmd_o.exec = (state_q == ST_EXEC);
  end

endmodule

// File: hw/rtl/two_stacks_shared_array.sv
// ----------------------------------------------------------------------------
// Two stacks shared array: top level
// Stack A grows up from entry 0, stack B grows down from entry DEPTH-1,
// both in one store of DEPTH words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one word: kind (push A,
//   push B, pop A, pop B) and value_in. Output channel out_valid_o /
//   out_stall_i returns one word per input: value_out and status (ok,
//   overflow on push into a full store, underflow on pop from an empty stack).
//   An accepted input word is latched, executed in the execute state and
//   its result registered; the result is offered in the response state.
//   The block takes no new word until the pending result leaves;
//   the single store read and write port is used in the execute state, then
//   the registered read data is presented.
//   A new input word is taken in the same cycle the pending result leaves.
//   While the receiver stalls, the result holds and no new word is taken.
//   Reset empties both stacks; the store contents are not cleared and no
//   pop can reach an entry that was never pushed.
// ----------------------------------------------------------------------------
module two_stacks_shared_array import tssa_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  cmd_t cmd;

  tssa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tssa_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  logic res_refused;
  logic status_known;

  assign res_refused  = out_valid_o && (out_data_o.status != STAT_OK);
  assign status_known = (out_data_o.status == STAT_OK) ||
                        (out_data_o.status == STAT_OVERFLOW) ||
                        (out_data_o.status == STAT_UNDERFLOW);

`include "two_stacks_shared_array_macros.svh"

  `TSSA_CHECK(a_accept_then_busy, (in_valid_i && !in_stall_o) |=> !out_valid_o)
  `TSSA_CHECK(a_refused_zero, res_refused |-> (out_data_o.value_out == '0))
  `TSSA_CHECK(a_status_code, out_valid_o |-> status_known)
  `TSSA_NEVER(a_no_take_while_held, !in_stall_o && out_valid_o && out_stall_i)

endmodule
